/* design/gus_pkg.sv */
// Shared types, constants and helpers for the 2x glyph upscaler.
`timescale 1ns / 1ps

package gus_pkg;

  localparam int unsigned SrcW    = 8;           // source row bits
  localparam int unsigned PixW    = 2 * SrcW;    // scaled row bits
  localparam int unsigned IdxW    = 4;           // output row index bits
  localparam int unsigned DimW    = 4;           // config register bits
  localparam int unsigned MaxDim  = 8;           // saturation limit for width and height
  localparam int unsigned AddrW   = 3;           // APB address bits
  localparam int unsigned RegW    = 32;          // APB data bits

  localparam logic [AddrW-1:0] AddrWidth  = 3'd0;
  localparam logic [AddrW-1:0] AddrHeight = 3'd4;

  // staircase patch rows, top to bottom
  localparam logic [3:0] Stair [4] = '{4'h3, 4'h7, 4'hE, 4'hC};

  // one queued job: up to four scaled rows
  typedef struct packed {
    logic [3:0][PixW-1:0] px;
    logic [IdxW-1:0]      base;   // row index of px[0]
    logic                 four;   // four rows, else two
    logic                 done;   // final row of the job ends the glyph
  } gus_job_t;

  // saturate a dimension register to 1..MaxDim
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    r = v;
    if (v == '0) r = DimW'(1);
    else if (v > DimW'(MaxDim)) r = DimW'(MaxDim);
    return r;
  endfunction

  // every source pixel becomes two output pixels
  function automatic logic [PixW-1:0] widen(input logic [SrcW-1:0] b);
    logic [PixW-1:0] r;
    for (int i = 0; i < SrcW; i++) r[2*i +: 2] = {2{b[i]}};
    return r;
  endfunction

endpackage

/* design/gus_front.sv */
// Front end: takes source rows, finds diagonal patches, builds row jobs.
`timescale 1ns / 1ps

module gus_front import gus_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [DimW-1:0] glyph_width_i,
  input  logic [DimW-1:0] glyph_height_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [SrcW-1:0] row_bits_i,
  output logic            push_o,
  input  logic            full_i,
  output gus_job_t        job_o
);

  logic [SrcW-1:0] prev_q, prev_d;
  logic [PixW-1:0] cu_q, cu_d, cl_q, cl_d;
  logic [IdxW-1:0] rc_q, rc_d;

  logic [DimW-1:0] w, h;
  logic [SrcW-1:0] mask, cur, prev;
  logic [PixW-1:0] pm, bp, bc;
  logic [3:0][PixW-1:0] p;
  logic            last, accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    w = clamp_dim(glyph_width_i);
    h = clamp_dim(glyph_height_i);
    for (int i = 0; i < SrcW; i++) mask[i] = (DimW'(i) < w);
    for (int i = 0; i < PixW; i++) pm[i] = (DimW'(i / 2) < w);
    cur  = row_bits_i & mask;
    prev = prev_q & mask;
    last = ({1'b0, rc_q} + 5'd1) >= {1'b0, h};
    bp   = widen(prev);
    bc   = widen(cur);
  end

  // bits past the width are zero, so pairs beyond it never match
  always_comb begin
    p = '0;
    for (int j = 0; j + 1 < SrcW; j++) begin
      if (!prev[j+1] && prev[j] && cur[j+1] && !cur[j]) begin
        for (int k = 0; k < 4; k++) p[k] = p[k] | (PixW'(Stair[k]) << (2 * j));
      end
      if (prev[j+1] && !prev[j] && !cur[j+1] && cur[j]) begin
        for (int k = 0; k < 4; k++) p[k] = p[k] | (PixW'(Stair[3-k]) << (2 * j));
      end
    end
  end

  always_comb begin
    prev_d = prev_q;
    cu_d   = cu_q;
    cl_d   = cl_q;
    rc_d   = rc_q;
    push_o = 1'b0;
    job_o  = '0;
    if (accept) begin
      if (rc_q == '0) begin
        cu_d = '0;
        cl_d = '0;
        if (last) begin
          push_o       = 1'b1;
          job_o.px[0]  = bc;
          job_o.px[1]  = bc;
          job_o.done   = 1'b1;
          prev_d       = '0;
        end else begin
          prev_d = cur;
          rc_d   = IdxW'(1);
        end
      end else begin
        push_o      = 1'b1;
        job_o.px[0] = (bp | cu_q | p[0]) & pm;
        job_o.px[1] = (bp | cl_q | p[1]) & pm;
        job_o.px[2] = (bc | p[2]) & pm;
        job_o.px[3] = (bc | p[3]) & pm;
        job_o.base  = IdxW'({rc_q, 1'b0} - 5'd2);
        job_o.four  = last;
        job_o.done  = last;
        if (last) begin
          prev_d = '0;
          cu_d   = '0;
          cl_d   = '0;
          rc_d   = '0;
        end else begin
          prev_d = cur;
          cu_d   = p[2];
          cl_d   = p[3];
          rc_d   = rc_q + IdxW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      cu_q   <= '0;
      cl_q   <= '0;
      rc_q   <= '0;
    end else begin
      prev_q <= prev_d;
      cu_q   <= cu_d;
      cl_q   <= cl_d;
      rc_q   <= rc_d;
    end
  end

endmodule

/* design/gus_fifo.sv */
// Two-entry job queue between front and back end.
`timescale 1ns / 1ps

module gus_fifo import gus_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  gus_job_t job_i,
  output logic     full_o,
  output logic     valid_o,
  input  logic     pop_i,
  output gus_job_t job_o
);

  gus_job_t   mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

/* design/gus_back.sv */
// Back end: plays queued jobs out one scaled row per beat.
`timescale 1ns / 1ps

module gus_back import gus_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  input  gus_job_t        job_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [PixW-1:0] pixel_row_o,
  output logic [IdxW-1:0] row_index_o,
  output logic            glyph_done_o
);

  logic [1:0]      sub_q, sub_d;
  logic            vld_q, vld_d;
  logic [PixW-1:0] px_q;
  logic [IdxW-1:0] idx_q;
  logic            done_q;
  logic            load, end_of_job;

  assign load       = job_valid_i && (!vld_q || out_ready_i);
  assign end_of_job = (sub_q == (job_i.four ? 2'd3 : 2'd1));
  assign pop_o      = load && end_of_job;

  always_comb begin
    sub_d = sub_q;
    vld_d = vld_q;
    if (load) begin
      sub_d = end_of_job ? 2'd0 : sub_q + 2'd1;
      vld_d = 1'b1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= '0;
      vld_q <= 1'b0;
    end else begin
      sub_q <= sub_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      px_q   <= job_i.px[sub_q];
      idx_q  <= job_i.base + IdxW'(sub_q);
      done_q <= end_of_job && job_i.done;
    end
  end

  assign out_valid_o  = vld_q;
  assign pixel_row_o  = px_q;
  assign row_index_o  = idx_q;
  assign glyph_done_o = done_q;

endmodule

/* design/glyph_upscale_2x_smooth.sv */
// Top level of the 2x glyph upscaler with diagonal smoothing.
`timescale 1ns / 1ps

// Usage:
//   s_axis carries one source glyph row per beat (tdata[7:0], leftmost
//   pixel at bit glyph_width-1). m_axis returns scaled rows, 2 per source
//   row: tdata[15:0] pixel row, tdata[19:16] row index, tlast marks the
//   final row of a glyph. The first source row of a glyph yields nothing
//   (unless height is 1); later rows yield two rows, the last row four.
//   APB registers: 0x0 glyph_width, 0x4 glyph_height (4 bits each); write
//   them only while the block is idle.
//   An accepted row's job goes into the job queue, then into the output
//   register. The output register drains one row per cycle while m_axis
//   is ready, so the m_axis beat rate sets the source row rate; the
//   two-entry job queue lets input run ahead briefly.
//   Reset clears the row counter, carried patch rows and the queue;
//   registers return to width 5, height 7.
//   When m_axis stalls the output row holds, the queue fills and
//   s_axis_tready drops; nothing is lost.

module glyph_upscale_2x_smooth import gus_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [RegW-1:0]  pwdata,
  output logic [RegW-1:0]  prdata,
  output logic             pready,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] row_bits
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [15:0] pixel_row, [19:16] row_index, rest 0
  output logic             m_axis_tlast    // glyph_done
);

  logic [DimW-1:0] gw_q, gh_q;
  logic            wr_en;

  logic     push, full, job_valid, pop;
  gus_job_t job_in, job_out;

  logic [PixW-1:0] pixel_row;
  logic [IdxW-1:0] row_index;

  // APB register file, pready tied high
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q <= DimW'(5);
      gh_q <= DimW'(7);
    end else if (wr_en) begin
      if (paddr == AddrWidth)  gw_q <= pwdata[DimW-1:0];
      if (paddr == AddrHeight) gh_q <= pwdata[DimW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == AddrWidth)  prdata = RegW'(gw_q);
    if (paddr == AddrHeight) prdata = RegW'(gh_q);
  end

  gus_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .glyph_width_i  (gw_q),
    .glyph_height_i (gh_q),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .row_bits_i     (s_axis_tdata),
    .push_o         (push),
    .full_i         (full),
    .job_o          (job_in)
  );

  gus_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .valid_o (job_valid),
    .pop_i   (pop),
    .job_o   (job_out)
  );

  gus_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (job_valid),
    .job_i        (job_out),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .pixel_row_o  (pixel_row),
    .row_index_o  (row_index),
    .glyph_done_o (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0, row_index, pixel_row};

endmodule
